// ===== rtl/awpb_pkg.sv =====
// Package for the alpha-weighted pixel blend: field widths, constants and the
// work item that travels from the front end to the divider pipeline.
// No dependencies.
package awpb_pkg;

  localparam int unsigned PixelW = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned SumW   = 17;
  localparam int unsigned DenW   = 9;
  localparam int unsigned QuoW   = 8;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ChanW-1:0] AlphaClear  = 8'h00;

  localparam int unsigned MidDepthDef = 4;
  localparam int unsigned OutDepthDef = 16;

  typedef struct packed {
    logic [NumChan-1:0][SumW-1:0] sum;
    logic [DenW-1:0]              den;
    logic [ChanW-1:0]             alpha;
  } blend_work_t;

endpackage

// ===== rtl/awpb_fifo.sv =====
// Small register-based first-in first-out queue with a combinational head.
// Depends on nothing; used for the work queue and the result queue.
module awpb_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);

endmodule

// ===== rtl/awpb_front.sv =====
// Front end of the blend: accepts pixel pairs, handles the both-transparent case
// and forms the weighted channel sums and the divisor. Depends on awpb_pkg.
module awpb_front import awpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [PixelW-1:0] first_pixel_i,
  input  logic [PixelW-1:0] second_pixel_i,
  output logic              valid_o,
  input  logic              ready_i,
  output blend_work_t       work_o
);

  logic        valid_q, valid_d;
  logic        accept;
  logic        both_clear;
  logic [ChanW-1:0] w0, w1;
  blend_work_t work_q, work_d;

  assign accept = push_i && !full_o;
  assign full_o = valid_q && !ready_i;

  always_comb begin
    both_clear = (first_pixel_i[31:24] == '0) && (second_pixel_i[31:24] == '0);
    w0 = both_clear ? ChanW'(1) : first_pixel_i[31:24];
    w1 = both_clear ? ChanW'(1) : second_pixel_i[31:24];
    for (int c = 0; c < NumChan; c++) begin
      work_d.sum[c] = SumW'(first_pixel_i[c*ChanW +: ChanW]) * SumW'(w0)
                    + SumW'(second_pixel_i[c*ChanW +: ChanW]) * SumW'(w1);
    end
    work_d.den   = DenW'(w0) + DenW'(w1);
    work_d.alpha = both_clear ? AlphaClear : AlphaOpaque;
    valid_d      = accept || (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== rtl/awpb_back.sv =====
// Back end of the blend: a restoring divider pipeline, one quotient bit per
// stage for each colour channel, that never stalls. Depends on awpb_pkg.
module awpb_back import awpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  blend_work_t       work_i,
  output logic              valid_o,
  output logic [PixelW-1:0] pixel_o
);

  localparam int unsigned Steps = QuoW;

  logic                         vld_q   [Steps];
  logic [NumChan-1:0][SumW-1:0] rem_q   [Steps];
  logic [NumChan-1:0][QuoW-1:0] quo_q   [Steps];
  logic [DenW-1:0]              den_q   [Steps];
  logic [ChanW-1:0]             alpha_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    localparam int unsigned Shift = Steps - 1 - k;

    logic                         vld_s;
    logic [NumChan-1:0][SumW-1:0] rem_s, rem_d;
    logic [NumChan-1:0][QuoW-1:0] quo_s, quo_d;
    logic [DenW-1:0]              den_s;
    logic [ChanW-1:0]             alpha_s;
    logic [SumW:0]                den_sh;

    if (k == 0) begin : g_head
      assign vld_s   = valid_i;
      assign rem_s   = work_i.sum;
      assign quo_s   = '0;
      assign den_s   = work_i.den;
      assign alpha_s = work_i.alpha;
    end else begin : g_body
      assign vld_s   = vld_q[k-1];
      assign rem_s   = rem_q[k-1];
      assign quo_s   = quo_q[k-1];
      assign den_s   = den_q[k-1];
      assign alpha_s = alpha_q[k-1];
    end

    assign den_sh = (SumW + 1)'(den_s) << Shift;

    always_comb begin
      logic [SumW:0] trial;
      for (int c = 0; c < NumChan; c++) begin
        trial = {1'b0, rem_s[c]} - den_sh;
        if (!trial[SumW]) begin
          rem_d[c] = trial[SumW-1:0];
          quo_d[c] = {quo_s[c][QuoW-2:0], 1'b1};
        end else begin
          rem_d[c] = rem_s[c];
          quo_d[c] = {quo_s[c][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_s) begin
        rem_q[k]   <= rem_d;
        quo_q[k]   <= quo_d;
        den_q[k]   <= den_s;
        alpha_q[k] <= alpha_s;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign pixel_o = {alpha_q[Steps-1], quo_q[Steps-1][2], quo_q[Steps-1][1],
                    quo_q[Steps-1][0]};

endmodule

// ===== rtl/alpha_weighted_pixel_blend.sv =====
// Alpha-weighted blend of two ARGB pixels. The block takes one pixel pair per
// clock while full is low and returns one blended pixel per clock while pop is
// high and the result queue is not empty. A pair is registered in the front end,
// which forms the weighted sums, then passes through a work queue of MidDepth
// entries into an eight-stage divider pipeline, one quotient bit a stage, and
// lands in a result queue of OutDepth entries. The divider only takes a new
// transaction while the result queue has room reserved for everything in
// flight, so OutDepth must be at least ten, the divider depth plus two, for
// full rate.
// Depends on awpb_pkg, awpb_front, awpb_back and awpb_fifo.
module alpha_weighted_pixel_blend import awpb_pkg::*; #(
  parameter int unsigned MidDepth = MidDepthDef,
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [PixelW-1:0] first_pixel_i,
  input  logic [PixelW-1:0] second_pixel_i,
  output logic              empty,
  input  logic              pop,
  output logic [PixelW-1:0] blended_pixel_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic        front_valid;
  blend_work_t front_work;
  logic        mid_full, mid_empty;
  blend_work_t mid_work;
  logic        issue;
  logic        back_valid;
  logic [PixelW-1:0] back_pixel;
  logic        out_full;
  logic        out_pop;
  logic [CntW-1:0] outstanding_q, outstanding_d;

  awpb_front u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .full_o         (full),
    .first_pixel_i,
    .second_pixel_i,
    .valid_o        (front_valid),
    .ready_i        (!mid_full),
    .work_o         (front_work)
  );

  awpb_fifo #(
    .Width ($bits(blend_work_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (front_valid && !mid_full),
    .data_i  (front_work),
    .pop_i   (issue),
    .data_o  (mid_work),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  assign issue = !mid_empty && (outstanding_q < CntW'(OutDepth));

  awpb_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (issue),
    .work_i  (mid_work),
    .valid_o (back_valid),
    .pixel_o (back_pixel)
  );

  assign out_pop = pop && !empty;

  awpb_fifo #(
    .Width (PixelW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (back_valid),
    .data_i  (back_pixel),
    .pop_i   (out_pop),
    .data_o  (blended_pixel_o),
    .full_o  (out_full),
    .empty_o (empty)
  );

  always_comb begin
    outstanding_d = outstanding_q;
    if (issue && !out_pop) begin
      outstanding_d = outstanding_q + CntW'(1);
    end else if (!issue && out_pop) begin
      outstanding_d = outstanding_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  // The credit count covers the divider and the result queue together.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= CntW'(OutDepth))
    else $error("More transactions in flight than the result queue can hold.");

  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_valid |-> !out_full)
    else $error("Divider delivered a result into a full result queue.");

  a_pop_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outstanding_q != '0)
    else $error("Result queue holds a pixel that carries no credit.");

  a_issue_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !mid_empty && outstanding_q < CntW'(OutDepth))
    else $error("Divider issued without work or without room for the result.");

endmodule
